### hw/rtl/dga_pkg.sv
// Shared types, constants and calendar tables for the Gregorian date unit.
// Used by the front, queue, back, checker and top-level modules; depends on nothing.
package dga_pkg;

  // Field widths of the input and result words.
  localparam int unsigned OP_W     = 3;
  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned OFFSET_W = 22;
  localparam int unsigned SCALAR_W = 22;
  localparam int unsigned CMP_W    = 2;

  // Internal widths.
  localparam int unsigned SERIAL_W = 23;  // serial day count up to year 16383
  localparam int unsigned SIGNED_W = 25;  // serial plus or minus an offset
  localparam int unsigned QY_W     = 8;   // year divided by 100
  localparam int unsigned DOY_W    = 9;   // day within a year
  localparam int unsigned PROD_W   = 27;  // year times the reciprocal of 100

  // Calendar constants.
  localparam int unsigned YEAR_LIMIT      = 16383;
  localparam int unsigned DAYS_400        = 146097;
  localparam int unsigned DAYS_100        = 36524;
  localparam int unsigned DAYS_4          = 1461;
  localparam int unsigned DAYS_1          = 365;
  localparam int unsigned CENTURY         = 100;
  localparam int unsigned MONTHS_PER_YEAR = 12;
  localparam int unsigned MONTH_FEB       = 2;
  localparam int unsigned LAST_YEAR_Q     = 3;   // last year of a 4-year or century span
  localparam int unsigned LAST_QUAD_Q     = 24;  // quad that holds a century year

  // Floor(y / 100) equals (y * RECIP_100) >> RECIP_SHIFT for every 14-bit y.
  localparam int unsigned RECIP_100   = 5243;
  localparam int unsigned RECIP_SHIFT = 19;

  localparam logic [SCALAR_W-1:0] SCALAR_MAX = '1;

  // Restoring division of a serial count: 6 quad-century, 2 century,
  // 5 four-year and 2 single-year steps.
  localparam int unsigned SPAN_STEPS = 15;
  localparam int unsigned STEP_W     = $clog2(SPAN_STEPS);

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic signed [CMP_W-1:0] CMP_LESS    = -2'sd1;
  localparam logic signed [CMP_W-1:0] CMP_EQUAL   = 2'sd0;
  localparam logic signed [CMP_W-1:0] CMP_GREATER = 2'sd1;

  typedef enum logic [OP_W-1:0] {
    OP_NEXT,
    OP_PREV,
    OP_ADD,
    OP_SUB,
    OP_COMPARE,
    OP_DAY_OF_YEAR,
    OP_SERIAL,
    OP_MONTH_LEN
  } op_t;

  typedef enum logic [1:0] {
    GRP_400,
    GRP_100,
    GRP_4,
    GRP_1
  } grp_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SER1,
    B_SER2,
    B_EVAL,
    B_SPAN,
    B_MONTH,
    B_DONE
  } bstate_t;

  // One division step: the span in days, the years it stands for, its group.
  typedef struct packed {
    logic [SERIAL_W-1:0] span;
    logic [YEAR_W-1:0]   years;
    grp_t                grp;
  } span_t;

  // A classified word as it travels from the front to the back.
  typedef struct packed {
    op_t                 op;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [OFFSET_W-1:0] offset;
    logic [YEAR_W-1:0]   oth_year;
    logic [MONTH_W-1:0]  oth_month;
    logic [DAY_W-1:0]    oth_day;
    logic                leap;
    logic                valid;
    logic [QY_W-1:0]     qcent;   // (year - 1) / 100
    logic [DAY_W-1:0]    mlen;
  } item_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:    len = leap ? DAY_W'(29) : DAY_W'(28);
      4'd4,
      4'd6,
      4'd9,
      4'd11:   len = DAY_W'(30);
      default: len = DAY_W'(31);
    endcase
    return len;
  endfunction

  // Days in the months before month m of a year.
  function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
    logic [DOY_W-1:0] base;
    case (m)
      4'd1:    base = DOY_W'(0);
      4'd2:    base = DOY_W'(31);
      4'd3:    base = DOY_W'(59);
      4'd4:    base = DOY_W'(90);
      4'd5:    base = DOY_W'(120);
      4'd6:    base = DOY_W'(151);
      4'd7:    base = DOY_W'(181);
      4'd8:    base = DOY_W'(212);
      4'd9:    base = DOY_W'(243);
      4'd10:   base = DOY_W'(273);
      4'd11:   base = DOY_W'(304);
      4'd12:   base = DOY_W'(334);
      default: base = DOY_W'(0);
    endcase
    if (leap && (m > MONTH_W'(MONTH_FEB))) begin
      base = base + DOY_W'(1);
    end
    return base;
  endfunction

  function automatic span_t span_step(input logic [STEP_W-1:0] idx);
    span_t s;
    case (idx)
      4'd0:    s = '{SERIAL_W'(DAYS_400 << 5), YEAR_W'(400 << 5), GRP_400};
      4'd1:    s = '{SERIAL_W'(DAYS_400 << 4), YEAR_W'(400 << 4), GRP_400};
      4'd2:    s = '{SERIAL_W'(DAYS_400 << 3), YEAR_W'(400 << 3), GRP_400};
      4'd3:    s = '{SERIAL_W'(DAYS_400 << 2), YEAR_W'(400 << 2), GRP_400};
      4'd4:    s = '{SERIAL_W'(DAYS_400 << 1), YEAR_W'(400 << 1), GRP_400};
      4'd5:    s = '{SERIAL_W'(DAYS_400), YEAR_W'(400), GRP_400};
      4'd6:    s = '{SERIAL_W'(DAYS_100 << 1), YEAR_W'(100 << 1), GRP_100};
      4'd7:    s = '{SERIAL_W'(DAYS_100), YEAR_W'(100), GRP_100};
      4'd8:    s = '{SERIAL_W'(DAYS_4 << 4), YEAR_W'(4 << 4), GRP_4};
      4'd9:    s = '{SERIAL_W'(DAYS_4 << 3), YEAR_W'(4 << 3), GRP_4};
      4'd10:   s = '{SERIAL_W'(DAYS_4 << 2), YEAR_W'(4 << 2), GRP_4};
      4'd11:   s = '{SERIAL_W'(DAYS_4 << 1), YEAR_W'(4 << 1), GRP_4};
      4'd12:   s = '{SERIAL_W'(DAYS_4), YEAR_W'(4), GRP_4};
      4'd13:   s = '{SERIAL_W'(DAYS_1 << 1), YEAR_W'(2), GRP_1};
      4'd14:   s = '{SERIAL_W'(DAYS_1), YEAR_W'(1), GRP_1};
      default: s = '{'0, '0, GRP_400};
    endcase
    return s;
  endfunction

endpackage

### hw/rtl/dga_front.sv
// Front end of the date unit: accepts input words and classifies them
// (leap year, month length, date validity). Depends on dga_pkg.
module dga_front import dga_pkg::*; #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OP_W-1:0]     in_opcode,
  input  logic [YEAR_W-1:0]   in_date_year,
  input  logic [MONTH_W-1:0]  in_date_month,
  input  logic [DAY_W-1:0]    in_date_day,
  input  logic [OFFSET_W-1:0] in_day_offset,
  input  logic [YEAR_W-1:0]   in_other_year,
  input  logic [MONTH_W-1:0]  in_other_month,
  input  logic [DAY_W-1:0]    in_other_day,
  input  logic                q_full,
  output logic                push,
  output item_t               push_item
);

  localparam int unsigned YMAX = (MAX_YEAR > YEAR_LIMIT) ? YEAR_LIMIT : MAX_YEAR;

  logic                f_valid_r, f_valid_nxt;
  logic [OP_W-1:0]     f_op_r;
  logic [YEAR_W-1:0]   f_year_r;
  logic [MONTH_W-1:0]  f_month_r;
  logic [DAY_W-1:0]    f_day_r;
  logic [OFFSET_W-1:0] f_offset_r;
  logic [YEAR_W-1:0]   f_oyear_r;
  logic [MONTH_W-1:0]  f_omonth_r;
  logic [DAY_W-1:0]    f_oday_r;
  logic [PROD_W-1:0]   f_prod_r, f_prod_nxt;
  logic                accept;

  logic [QY_W-1:0]     qy;
  logic [YEAR_W-1:0]   cent;
  logic                div100;
  logic                div400;
  logic                leap;
  logic [DAY_W-1:0]    mlen;
  logic                date_ok;

  // The holding register frees up whenever its word moves into the queue.
  assign push     = f_valid_r && !q_full;
  assign in_stall = f_valid_r && q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    f_valid_nxt = f_valid_r;
    if (accept) begin
      f_valid_nxt = 1'b1;
    end else if (push) begin
      f_valid_nxt = 1'b0;
    end
  end

  // The year times the reciprocal of 100 is registered with the word.
  assign f_prod_nxt = PROD_W'(in_date_year) * PROD_W'(RECIP_100);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_op_r     <= in_opcode;
      f_year_r   <= in_date_year;
      f_month_r  <= in_date_month;
      f_day_r    <= in_date_day;
      f_offset_r <= in_day_offset;
      f_oyear_r  <= in_other_year;
      f_omonth_r <= in_other_month;
      f_oday_r   <= in_other_day;
      f_prod_r   <= f_prod_nxt;
    end
  end

  // Leap-year rule: the century test checks the quotient by 100 back.
  assign qy     = f_prod_r[RECIP_SHIFT +: QY_W];
  assign cent   = YEAR_W'(qy) * YEAR_W'(CENTURY);
  assign div100 = (f_year_r == cent);
  assign div400 = div100 && (qy[1:0] == 2'b00);
  assign leap   = ((f_year_r[1:0] == 2'b00) && !div100) || div400;
  assign mlen   = month_len(f_month_r, leap);

  // Date validity covers year range, month range and day within the month.
  assign date_ok = (f_year_r != '0) && (f_year_r <= YEAR_W'(YMAX)) &&
                   (f_month_r != '0) && (f_month_r <= MONTH_W'(MONTHS_PER_YEAR)) &&
                   (f_day_r != '0) && (f_day_r <= mlen);

  always_comb begin
    push_item.op        = op_t'(f_op_r);
    push_item.year      = f_year_r;
    push_item.month     = f_month_r;
    push_item.day       = f_day_r;
    push_item.offset    = f_offset_r;
    push_item.oth_year  = f_oyear_r;
    push_item.oth_month = f_omonth_r;
    push_item.oth_day   = f_oday_r;
    push_item.leap      = leap;
    push_item.valid     = date_ok;
    // Whole centuries before the year: one less when the year itself ends one.
    push_item.qcent     = qy - QY_W'(div100);
    push_item.mlen      = mlen;
  end

endmodule

### hw/rtl/dga_queue.sv
// Short queue of classified words between the front and the back.
// Depends on dga_pkg for the word type and the depth.
module dga_queue import dga_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output logic  full,
  output logic  empty,
  output item_t head
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t             ent_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = ent_r[rd_ptr_r];

  // Pointers wrap at the depth; the count tracks occupancy.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### hw/rtl/dga_back.sv
// Back end of the date unit: a sequencer that converts dates to serial day
// counts and back, and drives the result register. Depends on dga_pkg.
module dga_back import dga_pkg::*; #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  input  item_t                      head,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [YEAR_W-1:0]          out_result_year,
  output logic [MONTH_W-1:0]         out_result_month,
  output logic [DAY_W-1:0]           out_result_day,
  output logic signed [CMP_W-1:0]    out_compare_result,
  output logic [SCALAR_W-1:0]        out_scalar_value,
  output logic                       out_error_flag
);

  localparam int unsigned YMAX = (MAX_YEAR > YEAR_LIMIT) ? YEAR_LIMIT : MAX_YEAR;
  localparam int unsigned PY   = YMAX - 1;
  localparam int unsigned YMAX_LEAP =
      (((YMAX % 4) == 0) && ((YMAX % 100) != 0)) || ((YMAX % 400) == 0) ? 1 : 0;
  // Serial count of December 31 of the last allowed year.
  localparam int unsigned SERIAL_LAST =
      PY * DAYS_1 + PY / 4 - PY / 100 + PY / 400 + (DAYS_1 - 1) + YMAX_LEAP;

  bstate_t                   st_r, st_nxt;
  item_t                     w_r, w_nxt;
  logic [SERIAL_W-1:0]       base_r, base_nxt;
  logic [SERIAL_W-1:0]       serial_r, serial_nxt;
  logic [SERIAL_W-1:0]       r_r, r_nxt;
  logic [YEAR_W-1:0]         yacc_r, yacc_nxt;
  logic [STEP_W-1:0]         step_r, step_nxt;
  logic [1:0]                q100_r, q100_nxt;
  logic [4:0]                q4_r, q4_nxt;
  logic [1:0]                q1_r, q1_nxt;
  logic [MONTH_W-1:0]        mon_r, mon_nxt;

  logic [YEAR_W-1:0]         res_year_r, res_year_nxt;
  logic [MONTH_W-1:0]        res_month_r, res_month_nxt;
  logic [DAY_W-1:0]          res_day_r, res_day_nxt;
  logic signed [CMP_W-1:0]   res_cmp_r, res_cmp_nxt;
  logic [SCALAR_W-1:0]       res_scal_r, res_scal_nxt;
  logic                      res_err_r, res_err_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [YEAR_W-1:0]         out_year_r;
  logic [MONTH_W-1:0]        out_month_r;
  logic [DAY_W-1:0]          out_day_r;
  logic signed [CMP_W-1:0]   out_cmp_r;
  logic [SCALAR_W-1:0]       out_scal_r;
  logic                      out_err_r;

  logic                      out_load;
  logic [YEAR_W-1:0]         p;
  logic signed [SIGNED_W-1:0] s_base;
  logic signed [SIGNED_W-1:0] s_delta;
  logic signed [SIGNED_W-1:0] s_val;
  logic                      is_date_op;
  logic                      range_bad;
  logic                      ser_sat;
  logic [DOY_W-1:0]          doy;
  logic signed [CMP_W-1:0]   cmp;
  span_t                     sp;
  logic                      take;
  logic                      rleap;
  logic [DAY_W-1:0]          ml;
  logic                      month_step;

  // Shared evaluation terms.
  assign p          = w_r.year - YEAR_W'(1);
  assign is_date_op = (w_r.op == OP_NEXT) || (w_r.op == OP_PREV) ||
                      (w_r.op == OP_ADD) || (w_r.op == OP_SUB);
  assign s_base     = $signed(SIGNED_W'(serial_r));
  assign s_delta    = ((w_r.op == OP_NEXT) || (w_r.op == OP_PREV)) ?
                      $signed(SIGNED_W'(1)) : $signed(SIGNED_W'(w_r.offset));
  assign s_val      = ((w_r.op == OP_NEXT) || (w_r.op == OP_ADD)) ?
                      (s_base + s_delta) : (s_base - s_delta);
  assign range_bad  = (s_val < $signed(SIGNED_W'(0))) ||
                      (s_val > $signed(SIGNED_W'(SERIAL_LAST)));
  assign ser_sat    = (serial_r > SERIAL_W'(SCALAR_MAX));
  assign doy        = days_before(w_r.month, w_r.leap) + DOY_W'(w_r.day) - DOY_W'(1);

  // Three-way compare on the raw fields, year first.
  always_comb begin
    if (w_r.year != w_r.oth_year) begin
      cmp = (w_r.year > w_r.oth_year) ? CMP_GREATER : CMP_LESS;
    end else if (w_r.month != w_r.oth_month) begin
      cmp = (w_r.month > w_r.oth_month) ? CMP_GREATER : CMP_LESS;
    end else if (w_r.day != w_r.oth_day) begin
      cmp = (w_r.day > w_r.oth_day) ? CMP_GREATER : CMP_LESS;
    end else begin
      cmp = CMP_EQUAL;
    end
  end

  // Division step and month walk terms.
  assign sp         = span_step(step_r);
  assign take       = (r_r >= sp.span);
  assign rleap      = (q1_r == 2'(LAST_YEAR_Q)) &&
                      !((q4_r == 5'(LAST_QUAD_Q)) && (q100_r != 2'(LAST_YEAR_Q)));
  assign ml         = month_len(mon_r, rleap);
  assign month_step = (r_r >= SERIAL_W'(ml)) && (mon_r < MONTH_W'(MONTHS_PER_YEAR));

  // Next state of the sequencer.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      B_IDLE: begin
        if (!q_empty) begin
          st_nxt = B_SER1;
        end
      end
      B_SER1: st_nxt = B_SER2;
      B_SER2: st_nxt = B_EVAL;
      B_EVAL: begin
        if (w_r.valid && is_date_op && !range_bad) begin
          st_nxt = B_SPAN;
        end else begin
          st_nxt = B_DONE;
        end
      end
      B_SPAN: begin
        if (step_r == STEP_W'(SPAN_STEPS - 1)) begin
          st_nxt = B_MONTH;
        end
      end
      B_MONTH: begin
        if (!month_step) begin
          st_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (!out_valid_r || !out_stall) begin
          st_nxt = B_IDLE;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    pop      = 1'b0;
    out_load = 1'b0;
    case (st_r)
      B_IDLE:  pop = !q_empty;
      B_DONE:  out_load = !out_valid_r || !out_stall;
      default: begin
        pop      = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  // Datapath next values.
  always_comb begin
    w_nxt         = w_r;
    base_nxt      = base_r;
    serial_nxt    = serial_r;
    r_nxt         = r_r;
    yacc_nxt      = yacc_r;
    step_nxt      = step_r;
    q100_nxt      = q100_r;
    q4_nxt        = q4_r;
    q1_nxt        = q1_r;
    mon_nxt       = mon_r;
    res_year_nxt  = res_year_r;
    res_month_nxt = res_month_r;
    res_day_nxt   = res_day_r;
    res_cmp_nxt   = res_cmp_r;
    res_scal_nxt  = res_scal_r;
    res_err_nxt   = res_err_r;
    case (st_r)
      B_IDLE: begin
        w_nxt = head;
      end
      B_SER1: begin
        base_nxt = SERIAL_W'(p) * SERIAL_W'(DAYS_1);
      end
      B_SER2: begin
        serial_nxt = base_r + SERIAL_W'(p >> 2) - SERIAL_W'(w_r.qcent) +
                     SERIAL_W'(w_r.qcent >> 2) +
                     SERIAL_W'(days_before(w_r.month, w_r.leap)) +
                     SERIAL_W'(w_r.day) - SERIAL_W'(1);
      end
      B_EVAL: begin
        // Default: the operand date echoes with nothing else set.
        res_year_nxt  = w_r.year;
        res_month_nxt = w_r.month;
        res_day_nxt   = w_r.day;
        res_cmp_nxt   = CMP_EQUAL;
        res_scal_nxt  = '0;
        res_err_nxt   = 1'b0;
        r_nxt         = s_val[SERIAL_W-1:0];
        yacc_nxt      = YEAR_W'(1);
        step_nxt      = '0;
        q100_nxt      = '0;
        q4_nxt        = '0;
        q1_nxt        = '0;
        mon_nxt       = MONTH_W'(1);
        if (!w_r.valid || (is_date_op && range_bad)) begin
          res_year_nxt  = '0;
          res_month_nxt = '0;
          res_day_nxt   = '0;
          res_err_nxt   = 1'b1;
        end else begin
          case (w_r.op)
            OP_COMPARE:     res_cmp_nxt = cmp;
            OP_DAY_OF_YEAR: res_scal_nxt = SCALAR_W'(doy);
            OP_SERIAL: begin
              if (ser_sat) begin
                res_scal_nxt = SCALAR_MAX;
                res_err_nxt  = 1'b1;
              end else begin
                res_scal_nxt = serial_r[SCALAR_W-1:0];
              end
            end
            OP_MONTH_LEN:   res_scal_nxt = SCALAR_W'(w_r.mlen);
            default:        res_scal_nxt = '0;
          endcase
        end
      end
      B_SPAN: begin
        // One restoring step: subtract the span if it fits.
        if (take) begin
          r_nxt    = r_r - sp.span;
          yacc_nxt = yacc_r + sp.years;
        end
        case (sp.grp)
          GRP_100: q100_nxt = {q100_r[0], take};
          GRP_4:   q4_nxt   = {q4_r[3:0], take};
          GRP_1:   q1_nxt   = {q1_r[0], take};
          default: q100_nxt = q100_r;
        endcase
        step_nxt = step_r + STEP_W'(1);
      end
      B_MONTH: begin
        if (month_step) begin
          r_nxt   = r_r - SERIAL_W'(ml);
          mon_nxt = mon_r + MONTH_W'(1);
        end else begin
          res_year_nxt  = yacc_r;
          res_month_nxt = mon_r;
          res_day_nxt   = r_r[DAY_W-1:0] + DAY_W'(1);
        end
      end
      default: begin
        w_nxt = w_r;
      end
    endcase
  end

  // The result register frees up when its word is taken.
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r         <= w_nxt;
    base_r      <= base_nxt;
    serial_r    <= serial_nxt;
    r_r         <= r_nxt;
    yacc_r      <= yacc_nxt;
    step_r      <= step_nxt;
    q100_r      <= q100_nxt;
    q4_r        <= q4_nxt;
    q1_r        <= q1_nxt;
    mon_r       <= mon_nxt;
    res_year_r  <= res_year_nxt;
    res_month_r <= res_month_nxt;
    res_day_r   <= res_day_nxt;
    res_cmp_r   <= res_cmp_nxt;
    res_scal_r  <= res_scal_nxt;
    res_err_r   <= res_err_nxt;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_year_r  <= res_year_r;
      out_month_r <= res_month_r;
      out_day_r   <= res_day_r;
      out_cmp_r   <= res_cmp_r;
      out_scal_r  <= res_scal_r;
      out_err_r   <= res_err_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_year    = out_year_r;
  assign out_result_month   = out_month_r;
  assign out_result_day     = out_day_r;
  assign out_compare_result = out_cmp_r;
  assign out_scalar_value   = out_scal_r;
  assign out_error_flag     = out_err_r;

endmodule

### hw/rtl/gregorian_date_arithmetic.sv
// Gregorian date arithmetic unit, top level.
// Input channel (in_*): opcode, operand date, day offset and second date;
// a word is taken at a clock edge with in_valid high and in_stall low.
// Result channel (out_*): result date, three-way compare, scalar value and
// error flag, one result word per input word, in order.
// The front registers and classifies each word and hands it to a two-entry
// queue; the back sequencer converts it and writes the result register.
// Each word passes the front register, the queue and the back states SER1,
// SER2 and EVAL; next, previous, add and subtract then run the 15
// restoring division steps over 400-, 100-, 4- and 1-year spans plus one
// step per month walked, while other operations, invalid dates and
// out-of-range results go straight to DONE, which loads the result register.
// The back handles one word at a time: it pops the next word only after
// the result register has taken the last one.
// A synchronous low rst_n empties the front, the queue and the result
// register. While out_stall is high the result word holds; the queue keeps
// accepting until it fills, and in_stall rises once the front also holds a word.
// Depends on dga_pkg, dga_front, dga_queue and dga_back.
module gregorian_date_arithmetic import dga_pkg::*; #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OP_W-1:0]         in_opcode,
  input  logic [YEAR_W-1:0]       in_date_year,
  input  logic [MONTH_W-1:0]      in_date_month,
  input  logic [DAY_W-1:0]        in_date_day,
  input  logic [OFFSET_W-1:0]     in_day_offset,
  input  logic [YEAR_W-1:0]       in_other_year,
  input  logic [MONTH_W-1:0]      in_other_month,
  input  logic [DAY_W-1:0]        in_other_day,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [YEAR_W-1:0]       out_result_year,
  output logic [MONTH_W-1:0]      out_result_month,
  output logic [DAY_W-1:0]        out_result_day,
  output logic signed [CMP_W-1:0] out_compare_result,
  output logic [SCALAR_W-1:0]     out_scalar_value,
  output logic                    out_error_flag
);

  logic  q_push;
  logic  q_pop;
  logic  q_full;
  logic  q_empty;
  item_t q_in;
  item_t q_head;

  // Front: accept and classify.
  dga_front #(
    .MAX_YEAR (MAX_YEAR)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_date_year   (in_date_year),
    .in_date_month  (in_date_month),
    .in_date_day    (in_date_day),
    .in_day_offset  (in_day_offset),
    .in_other_year  (in_other_year),
    .in_other_month (in_other_month),
    .in_other_day   (in_other_day),
    .q_full         (q_full),
    .push           (q_push),
    .push_item      (q_in)
  );

  // Queue between the two halves.
  dga_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  // Back: conversion sequencer and result register.
  dga_back #(
    .MAX_YEAR (MAX_YEAR)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .head               (q_head),
    .pop                (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_year    (out_result_year),
    .out_result_month   (out_result_month),
    .out_result_day     (out_result_day),
    .out_compare_result (out_compare_result),
    .out_scalar_value   (out_scalar_value),
    .out_error_flag     (out_error_flag)
  );

endmodule

### hw/rtl/dga_checker.sv
// Port-level checks for the Gregorian date unit and the bind that attaches
// them to the top level. Depends on dga_pkg.
module dga_checker import dga_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [YEAR_W-1:0]       out_result_year,
  input logic [MONTH_W-1:0]      out_result_month,
  input logic [DAY_W-1:0]        out_result_day,
  input logic signed [CMP_W-1:0] out_compare_result,
  input logic [SCALAR_W-1:0]     out_scalar_value,
  input logic                    out_error_flag
);

  // Reset empties the result register.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  // A stalled result word stays offered.
  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // An error word carries zeros, except a saturated serial count.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_flag && (out_scalar_value != SCALAR_MAX) |->
      (out_result_year == '0) && (out_result_month == '0) &&
      (out_result_day == '0) && (out_compare_result == CMP_EQUAL) &&
      (out_scalar_value == '0))
    else $error("error word carries nonzero fields");

  // A good word carries a plausible date and a compare code that exists.
  a_good_date: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_error_flag |->
      (out_result_year != '0) && (out_result_month != '0) &&
      (out_result_month <= MONTH_W'(MONTHS_PER_YEAR)) && (out_result_day != '0) &&
      ((out_compare_result == CMP_LESS) || (out_compare_result == CMP_EQUAL) ||
       (out_compare_result == CMP_GREATER)))
    else $error("good result word with an impossible date");

endmodule

bind gregorian_date_arithmetic dga_checker u_dga_checker (.*);
